// ===== hw/rtl/sfc_pkg.sv =====
// shared types and constants of the sensor frame codec
package sfc_pkg;

    localparam logic [7:0] FRAME_HDR0  = 8'hFF;
    localparam logic [7:0] FRAME_HDR1  = 8'h01;
    localparam logic [8:0] TEMP_OFFSET = 9'd40;

    // index of the checksum byte, the last byte of a frame
    localparam logic [3:0] LAST_POS = 4'd8;

    localparam logic CMD_SEND = 1'b0;
    localparam logic CMD_RECV = 1'b1;

    localparam logic KIND_TX      = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_HDR  = 2'd1;
    localparam logic [1:0] ST_BAD_ECHO = 2'd2;
    localparam logic [1:0] ST_BAD_SUM  = 2'd3;

    typedef struct packed {
        logic              hit;
        logic [1:0]        status;
        logic [15:0]       co2_ppm;
        logic signed [8:0] temperature_c;
    } t_rx_verdict;

    typedef struct packed {
        logic       busy;
        logic [7:0] tx_byte;
        logic       last;
    } t_tx_beat;

endpackage

// ===== hw/rtl/sfc_rx_check.sv =====
// response side: tracks received bytes and forms the verdict on the last one
module sfc_rx_check (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_send,
    input  logic [7:0]           i_cmd_code,
    input  logic                 i_rx,
    input  logic [7:0]           i_rx_byte,
    output sfc_pkg::t_rx_verdict o_verdict
);

    logic [7:0]  r_last_cmd;
    logic [3:0]  r_pos;
    logic [7:0]  r_sum;
    logic        r_hdr_good;
    logic        r_echo_good;
    logic [15:0] r_co2;
    logic [7:0]  r_temp_byte;

    logic [7:0]  n_sum;
    logic [8:0]  temp_raw;
    logic        at_end;

    assign at_end   = (r_pos >= sfc_pkg::LAST_POS);
    assign n_sum    = r_sum + i_rx_byte;
    assign temp_raw = {1'b0, r_temp_byte} - sfc_pkg::TEMP_OFFSET;

    always_comb begin
        o_verdict = '0;
        o_verdict.hit = i_rx && at_end;
        // header first, then echo, then checksum
        priority if (!r_hdr_good) begin
            o_verdict.status = sfc_pkg::ST_BAD_HDR;
        end else if (!r_echo_good) begin
            o_verdict.status = sfc_pkg::ST_BAD_ECHO;
        end else if (i_rx_byte != (8'd0 - r_sum)) begin
            o_verdict.status = sfc_pkg::ST_BAD_SUM;
        end else begin
            o_verdict.status = sfc_pkg::ST_OK;
        end
        if (o_verdict.status == sfc_pkg::ST_OK) begin
            o_verdict.co2_ppm       = r_co2;
            o_verdict.temperature_c = $signed(temp_raw);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_cmd  <= '0;
            r_pos       <= '0;
            r_sum       <= '0;
            r_hdr_good  <= 1'b0;
            r_echo_good <= 1'b0;
            r_co2       <= '0;
            r_temp_byte <= '0;
        end else if (i_send) begin
            // a new request drops any partial response
            r_last_cmd <= i_cmd_code;
            r_pos      <= '0;
            r_sum      <= '0;
        end else if (i_rx) begin
            if (r_pos == 4'd0) begin
                r_hdr_good <= (i_rx_byte == sfc_pkg::FRAME_HDR0);
                r_sum      <= '0;
                r_pos      <= 4'd1;
            end else if (!at_end) begin
                unique case (r_pos)
                    4'd1:    r_echo_good      <= (i_rx_byte == r_last_cmd);
                    4'd2:    r_co2[15:8]      <= i_rx_byte;
                    4'd3:    r_co2[7:0]       <= i_rx_byte;
                    4'd4:    r_temp_byte      <= i_rx_byte;
                    default: ;
                endcase
                r_sum <= n_sum;
                r_pos <= r_pos + 4'd1;
            end else begin
                r_pos <= '0;
            end
        end
    end

endmodule

// ===== hw/rtl/sfc_tx_frame.sv =====
// request side: builds a frame and shifts its bytes after the header out
module sfc_tx_frame (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic [7:0]        i_cmd_code,
    input  logic [7:0]        i_arg_b3,
    input  logic [7:0]        i_arg_b4,
    input  logic [7:0]        i_arg_b5,
    input  logic [7:0]        i_arg_b6,
    input  logic [7:0]        i_arg_b7,
    input  logic              i_advance,
    output sfc_pkg::t_tx_beat o_beat
);

    // frame bytes 1 to 8, byte 0 goes straight to the output register
    logic [7:0] r_shift [0:7];
    logic [3:0] r_left;
    logic       r_busy;

    logic [7:0] sum;
    logic [7:0] chk;

    assign sum = sfc_pkg::FRAME_HDR1 + i_cmd_code + i_arg_b3 + i_arg_b4
               + i_arg_b5 + i_arg_b6 + i_arg_b7;
    assign chk = 8'd0 - sum;

    assign o_beat.busy    = r_busy;
    assign o_beat.tx_byte = r_shift[0];
    assign o_beat.last    = (r_left == 4'd1);

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_shift[0] <= sfc_pkg::FRAME_HDR1;
            r_shift[1] <= i_cmd_code;
            r_shift[2] <= i_arg_b3;
            r_shift[3] <= i_arg_b4;
            r_shift[4] <= i_arg_b5;
            r_shift[5] <= i_arg_b6;
            r_shift[6] <= i_arg_b7;
            r_shift[7] <= chk;
        end else if (i_advance) begin
            for (int k = 0; k < 7; k++) begin
                r_shift[k] <= r_shift[k + 1];
            end
            r_shift[7] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_left <= '0;
        end else if (i_load) begin
            r_busy <= 1'b1;
            r_left <= sfc_pkg::LAST_POS;
        end else if (i_advance && r_busy) begin
            r_left <= r_left - 4'd1;
            if (r_left == 4'd1) begin
                r_busy <= 1'b0;
            end
        end
    end

endmodule

// ===== hw/rtl/sensor_frame_codec.sv =====
// top level of the sensor frame codec
// a receive item is accepted every o_ready cycle; its verdict, if any, shows next cycle
// a send item shows its header byte in the next cycle and holds the input until all
// nine beats reach the single output register, one per cycle unless the output stalls
// i_rst_n, synchronous and active low, clears o_valid and frame state but the shifter
module sensor_frame_codec (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic              i_command,
    input  logic [7:0]        i_cmd_code,
    input  logic [7:0]        i_arg_b3,
    input  logic [7:0]        i_arg_b4,
    input  logic [7:0]        i_arg_b5,
    input  logic [7:0]        i_arg_b6,
    input  logic [7:0]        i_arg_b7,
    input  logic [7:0]        i_rx_byte,
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_kind,
    output logic [7:0]        o_tx_byte,
    output logic              o_last,
    output logic [1:0]        o_status,
    output logic [15:0]       o_co2_ppm,
    output logic signed [8:0] o_temperature_c
);

    sfc_pkg::t_rx_verdict verdict;
    sfc_pkg::t_tx_beat    beat;

    logic slot_free;
    logic accept;
    logic send;
    logic recv;
    logic tx_adv;

    logic              r_valid;
    logic              r_kind;
    logic [7:0]        r_tx_byte;
    logic              r_last;
    logic [1:0]        r_status;
    logic [15:0]       r_co2;
    logic signed [8:0] r_temp;

    logic              n_valid;
    logic              n_kind;
    logic [7:0]        n_tx_byte;
    logic              n_last;
    logic [1:0]        n_status;
    logic [15:0]       n_co2;
    logic signed [8:0] n_temp;

    assign slot_free = !r_valid || i_ready;
    assign o_ready   = slot_free && !beat.busy;
    assign accept    = i_valid && o_ready;
    assign send      = accept && (i_command == sfc_pkg::CMD_SEND);
    assign recv      = accept && (i_command == sfc_pkg::CMD_RECV);
    assign tx_adv    = slot_free && beat.busy;

    sfc_rx_check u_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_send     (send),
        .i_cmd_code (i_cmd_code),
        .i_rx       (recv),
        .i_rx_byte  (i_rx_byte),
        .o_verdict  (verdict)
    );

    sfc_tx_frame u_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (send),
        .i_cmd_code (i_cmd_code),
        .i_arg_b3   (i_arg_b3),
        .i_arg_b4   (i_arg_b4),
        .i_arg_b5   (i_arg_b5),
        .i_arg_b6   (i_arg_b6),
        .i_arg_b7   (i_arg_b7),
        .i_advance  (tx_adv),
        .o_beat     (beat)
    );

    always_comb begin
        n_valid   = r_valid && !i_ready;
        n_kind    = r_kind;
        n_tx_byte = r_tx_byte;
        n_last    = r_last;
        n_status  = r_status;
        n_co2     = r_co2;
        n_temp    = r_temp;
        priority if (send) begin
            n_valid   = 1'b1;
            n_kind    = sfc_pkg::KIND_TX;
            n_tx_byte = sfc_pkg::FRAME_HDR0;
            n_last    = 1'b0;
            n_status  = sfc_pkg::ST_OK;
            n_co2     = '0;
            n_temp    = '0;
        end else if (recv && verdict.hit) begin
            n_valid   = 1'b1;
            n_kind    = sfc_pkg::KIND_VERDICT;
            n_tx_byte = '0;
            n_last    = 1'b1;
            n_status  = verdict.status;
            n_co2     = verdict.co2_ppm;
            n_temp    = verdict.temperature_c;
        end else if (tx_adv) begin
            n_valid   = 1'b1;
            n_kind    = sfc_pkg::KIND_TX;
            n_tx_byte = beat.tx_byte;
            n_last    = beat.last;
            n_status  = sfc_pkg::ST_OK;
            n_co2     = '0;
            n_temp    = '0;
        end else begin
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_tx_byte <= n_tx_byte;
        r_last    <= n_last;
        r_status  <= n_status;
        r_co2     <= n_co2;
        r_temp    <= n_temp;
    end

    assign o_valid         = r_valid;
    assign o_kind          = r_kind;
    assign o_tx_byte       = r_tx_byte;
    assign o_last          = r_last;
    assign o_status        = r_status;
    assign o_co2_ppm       = r_co2;
    assign o_temperature_c = r_temp;

endmodule

// ===== hw/rtl/sfc_checker.sv =====
// port-level checks of the sensor frame codec, bound to the top level
module sfc_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_ready,
    input logic              i_command,
    input logic [7:0]        i_cmd_code,
    input logic [7:0]        i_arg_b3,
    input logic [7:0]        i_arg_b4,
    input logic [7:0]        i_arg_b5,
    input logic [7:0]        i_arg_b6,
    input logic [7:0]        i_arg_b7,
    input logic [7:0]        i_rx_byte,
    input logic              o_valid,
    input logic              i_ready,
    input logic              o_kind,
    input logic [7:0]        o_tx_byte,
    input logic              o_last,
    input logic [1:0]        o_status,
    input logic [15:0]       o_co2_ppm,
    input logic signed [8:0] o_temperature_c
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_tx_byte) && $stable(o_kind)
            && $stable(o_last) && $stable(o_status))
        else $error("output item changed while stalled");

    // an accepted send shows its header byte next
    a_send_hdr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && (i_command == sfc_pkg::CMD_SEND) |=>
            o_valid && (o_kind == sfc_pkg::KIND_TX)
            && (o_tx_byte == sfc_pkg::FRAME_HDR0) && !o_last)
        else $error("send did not start with the header byte");

    a_verdict_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == sfc_pkg::KIND_VERDICT) |-> o_last && (o_tx_byte == 8'd0))
        else $error("verdict item malformed");

    a_tx_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == sfc_pkg::KIND_TX) |->
            (o_status == sfc_pkg::ST_OK) && (o_co2_ppm == 16'd0)
            && (o_temperature_c == 9'sd0))
        else $error("transmit item carries verdict fields");

    a_bad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == sfc_pkg::KIND_VERDICT) && (o_status != sfc_pkg::ST_OK) |->
            (o_co2_ppm == 16'd0) && (o_temperature_c == 9'sd0))
        else $error("failed verdict carries readings");

endmodule

bind sensor_frame_codec sfc_checker u_sfc_checker (.*);

// ===== sim/tb_sensor_frame_codec.sv =====
// testbench for the sensor frame codec: request frames, response verdicts, random traffic
module tb_sensor_frame_codec;
    import sfc_pkg::*;

    typedef logic [8:0][7:0] t_frame;

    typedef struct packed {
        logic        kind;
        logic [7:0]  tx_byte;
        logic        last;
        logic [1:0]  status;
        logic [15:0] co2_ppm;
        logic [8:0]  temperature_c;
    } t_codec_beat;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    logic              i_command;
    logic [7:0]        i_cmd_code;
    logic [7:0]        i_arg_b3;
    logic [7:0]        i_arg_b4;
    logic [7:0]        i_arg_b5;
    logic [7:0]        i_arg_b6;
    logic [7:0]        i_arg_b7;
    logic [7:0]        i_rx_byte;
    logic              o_valid;
    logic              i_ready = 1'b0;
    logic              o_kind;
    logic [7:0]        o_tx_byte;
    logic              o_last;
    logic [1:0]        o_status;
    logic [15:0]       o_co2_ppm;
    logic signed [8:0] o_temperature_c;

    // shadow copy of the codec state
    logic [7:0]  sh_last_cmd = '0;
    logic [3:0]  sh_pos = '0;
    logic [7:0]  sh_sum = '0;
    logic        sh_hdr_ok = 1'b0;
    logic        sh_echo_ok = 1'b0;
    logic [15:0] sh_co2 = '0;
    logic [7:0]  sh_temp_byte = '0;

    t_codec_beat beats_due[$];

    int   fail_cnt = 0;
    int   items_sent = 0;
    int   tx_seen = 0;
    int   verdicts_seen[4] = '{0, 0, 0, 0};
    int   stall_left = 0;
    logic no_gap = 1'b0;
    logic no_stall = 1'b0;
    logic [7:0] sent_cmd = '0;

    sensor_frame_codec u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_command       (i_command),
        .i_cmd_code      (i_cmd_code),
        .i_arg_b3        (i_arg_b3),
        .i_arg_b4        (i_arg_b4),
        .i_arg_b5        (i_arg_b5),
        .i_arg_b6        (i_arg_b6),
        .i_arg_b7        (i_arg_b7),
        .i_rx_byte       (i_rx_byte),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_kind          (o_kind),
        .o_tx_byte       (o_tx_byte),
        .o_last          (o_last),
        .o_status        (o_status),
        .o_co2_ppm       (o_co2_ppm),
        .o_temperature_c (o_temperature_c)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // two's complement of the byte sum of frame bytes 1 to 7
    function automatic logic [7:0] frame_checksum(input t_frame fr);
        logic [7:0] s;
        s = '0;
        for (int i = 1; i < 8; i++) s = s + fr[i];
        return 8'h00 - s;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic void log_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) $display("%s", msg);
    endfunction

    function automatic void run_codec_item(input logic cmd, input logic [7:0] code,
                                           input logic [7:0] a3, a4, a5, a6, a7, rx);
        t_frame      fr;
        t_codec_beat b;
        if (cmd == CMD_SEND) begin
            fr[0] = FRAME_HDR0;
            fr[1] = FRAME_HDR1;
            fr[2] = code;
            fr[3] = a3;
            fr[4] = a4;
            fr[5] = a5;
            fr[6] = a6;
            fr[7] = a7;
            fr[8] = frame_checksum(fr);
            sh_last_cmd = code;
            sh_pos = '0;
            sh_sum = '0;
            for (int i = 0; i < 9; i++) begin
                b = '0;
                b.kind = KIND_TX;
                b.tx_byte = fr[i];
                b.last = (i == 8);
                beats_due.push_back(b);
            end
        end else if (sh_pos == 0) begin
            sh_hdr_ok = (rx == FRAME_HDR0);
            sh_sum = '0;
            sh_pos = 4'd1;
        end else if (sh_pos < LAST_POS) begin
            case (sh_pos)
                4'd1: sh_echo_ok = (rx == sh_last_cmd);
                4'd2: sh_co2[15:8] = rx;
                4'd3: sh_co2[7:0] = rx;
                4'd4: sh_temp_byte = rx;
                default: ;
            endcase
            sh_sum = sh_sum + rx;
            sh_pos = sh_pos + 4'd1;
        end else begin
            b = '0;
            b.kind = KIND_VERDICT;
            b.last = 1'b1;
            if (!sh_hdr_ok) b.status = ST_BAD_HDR;
            else if (!sh_echo_ok) b.status = ST_BAD_ECHO;
            else if (rx != 8'h00 - sh_sum) b.status = ST_BAD_SUM;
            else b.status = ST_OK;
            if (b.status == ST_OK) begin
                b.co2_ppm = sh_co2;
                b.temperature_c = {1'b0, sh_temp_byte} - TEMP_OFFSET;
            end
            sh_pos = '0;
            beats_due.push_back(b);
        end
    endfunction

    // result check first, then the accepted item updates the shadow state
    always @(posedge i_clk) begin : scoreboard
        t_codec_beat got;
        t_codec_beat want;
        if (i_rst_n) begin
            if (o_valid && i_ready) begin
                got = {o_kind, o_tx_byte, o_last, o_status, o_co2_ppm, o_temperature_c};
                if (beats_due.size() == 0) begin
                    log_fail($sformatf("unexpected item: kind=%0d tx=%02h last=%0d st=%0d",
                                       got.kind, got.tx_byte, got.last, got.status));
                end else begin
                    want = beats_due.pop_front();
                    if (got.kind !== want.kind || got.tx_byte !== want.tx_byte ||
                        got.last !== want.last || got.status !== want.status ||
                        got.co2_ppm !== want.co2_ppm ||
                        got.temperature_c !== want.temperature_c) begin
                        log_fail($sformatf(
                            "mismatch exp kind=%0d tx=%02h last=%0d st=%0d co2=%0d t=%0d",
                            want.kind, want.tx_byte, want.last, want.status,
                            want.co2_ppm, $signed(want.temperature_c)));
                        if (fail_cnt <= 10)
                            $display("         got kind=%0d tx=%02h last=%0d st=%0d co2=%0d t=%0d",
                                     got.kind, got.tx_byte, got.last, got.status,
                                     got.co2_ppm, $signed(got.temperature_c));
                    end
                end
                if (got.kind == KIND_TX) tx_seen++;
                else verdicts_seen[got.status]++;
            end
            if (i_valid && o_ready)
                run_codec_item(i_command, i_cmd_code, i_arg_b3, i_arg_b4, i_arg_b5,
                               i_arg_b6, i_arg_b7, i_rx_byte);
        end
    end

    // receiver stalls
    always @(posedge i_clk) begin
        if (no_stall) begin
            i_ready <= 1'b1;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 99) < 25) begin
            i_ready <= 1'b0;
            stall_left <= idle_len() - 1;
        end else begin
            i_ready <= 1'b1;
        end
    end

    task automatic drive_item(input logic cmd, input logic [7:0] code,
                              input logic [7:0] a3, a4, a5, a6, a7, rx);
        int gap;
        gap = 0;
        if (!no_gap && $urandom_range(0, 99) < 35) gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_cmd_code <= code;
        i_arg_b3 <= a3;
        i_arg_b4 <= a4;
        i_arg_b5 <= a5;
        i_arg_b6 <= a6;
        i_arg_b7 <= a7;
        i_rx_byte <= rx;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic send_request(input logic [7:0] code, input logic [39:0] args);
        sent_cmd = code;
        drive_item(CMD_SEND, code, args[39:32], args[31:24], args[23:16], args[15:8],
                   args[7:0], 8'($urandom));
    endtask

    // the unused fields of a receive item carry random values
    task automatic recv_bytes(input t_frame fr, input int n);
        for (int i = 0; i < n; i++)
            drive_item(CMD_RECV, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                       8'($urandom), 8'($urandom), fr[i]);
    endtask

    function automatic t_frame make_response(input logic [7:0] echo, input logic [15:0] co2,
                                             input logic [7:0] temp_byte);
        t_frame fr;
        fr[0] = FRAME_HDR0;
        fr[1] = echo;
        fr[2] = co2[15:8];
        fr[3] = co2[7:0];
        fr[4] = temp_byte;
        fr[5] = 8'($urandom);
        fr[6] = 8'($urandom);
        fr[7] = 8'($urandom);
        fr[8] = frame_checksum(fr);
        return fr;
    endfunction

    task automatic wait_drained();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (beats_due.size() != 0) @(posedge i_clk);
    endtask

    // echo compared against the cleared command register, with max co2 and temperature
    task automatic test_echo_after_reset();
        recv_bytes(make_response(8'h00, 16'hFFFF, 8'hFF), 9);
    endtask

    task automatic test_request_extremes();
        send_request(8'h00, 40'h00_0000_0000);
        send_request(8'hFF, 40'hFF_FFFF_FFFF);
    endtask

    // a request in the middle of a response restarts the receive side
    task automatic test_request_cuts_response();
        recv_bytes(make_response(sent_cmd, 16'h1234, 8'h28), 4);
        send_request(8'h86, {8'($urandom), 32'($urandom)});
    endtask

    // wrong echo and wrong checksum together: the echo fault is reported
    task automatic test_echo_over_checksum();
        t_frame fr;
        fr = make_response(sent_cmd ^ 8'h01, 16'h0000, 8'h00);
        fr[8] = fr[8] ^ 8'h5A;
        recv_bytes(fr, 9);
    endtask

    task automatic test_back_to_back();
        no_gap = 1'b1;
        no_stall = 1'b1;
        for (int k = 0; k < 4; k++) begin
            send_request(k[0] ? 8'h86 : 8'($urandom), {8'($urandom), 32'($urandom)});
            recv_bytes(make_response(sent_cmd, 16'($urandom), 8'($urandom)), 9);
        end
        wait_drained();
        no_gap = 1'b0;
        no_stall = 1'b0;
    endtask

    task automatic test_random_traffic(input int target);
        t_frame      fr;
        int          r;
        int          fault;
        logic [15:0] co2;
        while (items_sent < target) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                wait_drained();
            end else if (r < 15) begin
                send_request(($urandom_range(0, 1) == 0) ? 8'h86 : 8'($urandom),
                             {8'($urandom), 32'($urandom)});
            end else if (r < 24) begin
                // broken response cut short by a fresh request
                for (int i = 0; i < 9; i++) fr[i] = 8'($urandom);
                recv_bytes(fr, $urandom_range(1, 8));
                send_request(8'($urandom), {8'($urandom), 32'($urandom)});
            end else begin
                case ($urandom_range(0, 9))
                    0: co2 = 16'h0000;
                    1: co2 = 16'hFFFF;
                    default: co2 = 16'($urandom);
                endcase
                fr = make_response(sent_cmd, co2, 8'($urandom));
                fault = $urandom_range(0, 9);
                if (fault == 0 || fault == 3) fr[0] = 8'($urandom_range(0, 254));
                if (fault == 1 || fault == 3) fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
                if (fault == 2 || fault == 3) fr[8] = fr[8] ^ 8'($urandom_range(1, 255));
                recv_bytes(fr, 9);
            end
        end
    endtask

    initial begin
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_command <= CMD_SEND;
        i_cmd_code <= '0;
        i_arg_b3 <= '0;
        i_arg_b4 <= '0;
        i_arg_b5 <= '0;
        i_arg_b6 <= '0;
        i_arg_b7 <= '0;
        i_rx_byte <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_echo_after_reset();
        test_request_extremes();
        test_request_cuts_response();
        test_echo_over_checksum();
        wait_drained();
        test_back_to_back();
        test_random_traffic(460);

        wait_drained();
        repeat (16) @(posedge i_clk);

        $display("sent %0d items, checked %0d request bytes", items_sent, tx_seen);
        $display("verdicts ok %0d, bad header %0d, bad echo %0d, bad checksum %0d",
                 verdicts_seen[ST_OK], verdicts_seen[ST_BAD_HDR],
                 verdicts_seen[ST_BAD_ECHO], verdicts_seen[ST_BAD_SUM]);
        if (fail_cnt == 0 && beats_due.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("%0d mismatches, %0d items still due", fail_cnt, beats_due.size());
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
